// ===== rtl/cbec_pkg.sv =====
// ----------------------------------------------------------------------------
// cbec_pkg - shared types and constants for the bit-serial crc block
// Item and result words, command classes, register indexes and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package cbec_pkg;

  localparam int MAX_DEGREE_DEFAULT = 32;
  localparam int ITEM_Q_DEPTH       = 4;
  localparam int CFG_IDX_W          = 1;
  localparam int CFG_DATA_W         = 32;
  localparam int GEN_LOW_W          = 32;
  localparam int DEG_CFG_W          = 6;
  localparam int REM_OUT_W          = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GEN_LOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_DEG = 1'b1;

  localparam logic [GEN_LOW_W-1:0] GEN_LOW_RESET = '0;
  localparam logic [DEG_CFG_W-1:0] GEN_DEG_RESET = 6'd1;

  // command class decided at the front
  typedef enum logic [1:0] {
    OP_ENC,
    OP_ENC_LAST,
    OP_CHK,
    OP_CHK_LAST
  } op_t;

  typedef struct packed {
    op_t  op;
    logic data_bit;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic                 code_bit;
    logic                 is_check_bit;
    logic                 end_of_run;
    logic                 is_verdict;
    logic [REM_OUT_W-1:0] remainder_value;
    logic                 error_found;
  } result_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/cbec_front.sv =====
// ----------------------------------------------------------------------------
// cbec_front - input side of the crc block
// Takes input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cbec_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire logic           command,
  input  wire logic           data_bit,
  input  wire logic           last_bit,
  output cbec_pkg::head_t     head,
  input  wire logic           take
);

  localparam int Depth = cbec_pkg::ITEM_Q_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  cbec_pkg::item_t           q_mem [Depth];
  logic [PtrW-1:0]           wr_ptr;
  logic [PtrW-1:0]           rd_ptr;
  logic [CntW-1:0]           count;
  cbec_pkg::item_t           item_in;
  logic                      push_ok;
  logic                      take_ok;

  always_comb begin
    item_in.data_bit = data_bit;
    unique case ({command, last_bit})
      2'b00:   item_in.op = cbec_pkg::OP_ENC;
      2'b01:   item_in.op = cbec_pkg::OP_ENC_LAST;
      2'b10:   item_in.op = cbec_pkg::OP_CHK;
      2'b11:   item_in.op = cbec_pkg::OP_CHK_LAST;
      default: item_in.op = cbec_pkg::OP_ENC;
    endcase
  end

  assign full    = (count == CntW'(Depth));
  assign push_ok = push && !full;
  assign take_ok = take && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (take_ok) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push_ok && !take_ok) begin
        count <= count + CntW'(1);
      end else if (take_ok && !push_ok) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cbec_back.sv =====
// ----------------------------------------------------------------------------
// cbec_back - divider and result side of the crc block
// Runs the remainder register, the crc tail sequencer and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cbec_back #(
  parameter int MAX_DEGREE = cbec_pkg::MAX_DEGREE_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [cbec_pkg::GEN_LOW_W-1:0]    gen_low,
  input  wire logic [cbec_pkg::DEG_CFG_W-1:0]    gen_degree,
  input  wire cbec_pkg::head_t                   head,
  output logic                                   take,
  input  wire logic                              pop,
  output logic                                   empty,
  output cbec_pkg::result_t                      result
);

  localparam int DegW = $clog2(MAX_DEGREE + 1);
  localparam int IdxW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam logic [6:0] MaxDeg7 = 7'(MAX_DEGREE);

  cbec_pkg::back_state_t     state;
  cbec_pkg::back_state_t     state_next;
  logic [MAX_DEGREE-1:0]     rem;
  logic [MAX_DEGREE-1:0]     rem_next;
  logic [DegW-1:0]           cnt;
  logic [DegW-1:0]           cnt_next;

  logic [6:0]                deg7;
  logic [6:0]                eff7;
  logic [DegW-1:0]           eff;
  logic [DegW-1:0]           dm1;
  logic [IdxW-1:0]           top_idx;
  logic [MAX_DEGREE-1:0]     mask;
  logic [63:0]               gen64;
  logic [MAX_DEGREE-1:0]     gen_m;
  logic [MAX_DEGREE-1:0]     sh_base;
  logic [MAX_DEGREE-1:0]     sh_fb;
  logic [MAX_DEGREE-1:0]     sh_in;
  logic [MAX_DEGREE-1:0]     sh_zero;
  logic [63:0]               sh_in64;

  cbec_pkg::result_t         res;
  logic                      res_wr;

  // result queue, two words
  cbec_pkg::result_t         oq [2];
  logic                      oq_wp;
  logic                      oq_rp;
  logic [1:0]                oq_cnt;
  logic                      pop_ok;
  logic                      room;

  // effective degree, clamped to one .. MAX_DEGREE
  always_comb begin
    deg7 = {1'b0, gen_degree};
    if (deg7 == 7'd0) begin
      eff7 = 7'd1;
    end else if (deg7 > MaxDeg7) begin
      eff7 = MaxDeg7;
    end else begin
      eff7 = deg7;
    end
  end

  assign eff     = DegW'(eff7);
  assign dm1     = eff - DegW'(1);
  assign top_idx = dm1[IdxW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i] = (DegW'(i) < eff);
    end
  end

  assign gen64   = {32'b0, gen_low};
  assign gen_m   = gen64[MAX_DEGREE-1:0] & mask;
  assign sh_base = (rem << 1) & mask;
  assign sh_fb   = rem[top_idx] ? gen_m : '0;
  assign sh_in   = (sh_base | MAX_DEGREE'(head.item.data_bit)) ^ sh_fb;
  assign sh_zero = sh_base ^ sh_fb;
  assign sh_in64 = 64'(sh_in);

  assign empty  = (oq_cnt == 2'd0);
  assign pop_ok = pop && !empty;
  assign room   = (oq_cnt != 2'd2) || pop_ok;
  assign result = oq[oq_rp];

  always_comb begin
    state_next = state;
    rem_next   = rem;
    cnt_next   = cnt;
    take       = 1'b0;
    res_wr     = 1'b0;
    res        = '0;
    unique case (state)
      cbec_pkg::ST_RUN: begin
        if (head.valid) begin
          unique case (head.item.op)
            cbec_pkg::OP_ENC: begin
              if (room) begin
                take         = 1'b1;
                rem_next     = sh_in;
                res_wr       = 1'b1;
                res.code_bit = head.item.data_bit;
              end
            end
            cbec_pkg::OP_ENC_LAST: begin
              if (room) begin
                take         = 1'b1;
                rem_next     = sh_in;
                res_wr       = 1'b1;
                res.code_bit = head.item.data_bit;
                cnt_next     = '0;
                state_next   = cbec_pkg::ST_FLUSH;
              end
            end
            cbec_pkg::OP_CHK: begin
              take     = 1'b1;
              rem_next = sh_in;
            end
            cbec_pkg::OP_CHK_LAST: begin
              if (room) begin
                take                = 1'b1;
                rem_next            = '0;
                res_wr              = 1'b1;
                res.end_of_run      = 1'b1;
                res.is_verdict      = 1'b1;
                res.remainder_value = sh_in64[cbec_pkg::REM_OUT_W-1:0];
                res.error_found     = |sh_in;
              end
            end
            default: begin
              take = 1'b0;
            end
          endcase
        end
      end
      cbec_pkg::ST_FLUSH: begin
        // shift in degree zeros to form the crc
        rem_next = sh_zero;
        if (cnt == dm1) begin
          cnt_next   = '0;
          state_next = cbec_pkg::ST_EMIT;
        end else begin
          cnt_next = cnt + DegW'(1);
        end
      end
      cbec_pkg::ST_EMIT: begin
        if (room) begin
          res_wr           = 1'b1;
          res.code_bit     = rem[top_idx];
          res.is_check_bit = 1'b1;
          res.end_of_run   = (cnt == dm1);
          rem_next         = sh_base;
          if (cnt == dm1) begin
            rem_next   = '0;
            cnt_next   = '0;
            state_next = cbec_pkg::ST_RUN;
          end else begin
            cnt_next = cnt + DegW'(1);
          end
        end
      end
      default: begin
        state_next = cbec_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbec_pkg::ST_RUN;
      rem   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      rem   <= rem_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      oq[oq_wp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= 1'b0;
      oq_rp  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (res_wr) begin
        oq_wp <= ~oq_wp;
      end
      if (pop_ok) begin
        oq_rp <= ~oq_rp;
      end
      if (res_wr && !pop_ok) begin
        oq_cnt <= oq_cnt + 2'd1;
      end else if (pop_ok && !res_wr) begin
        oq_cnt <= oq_cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crc_bit_serial_encode_check.sv =====
// ----------------------------------------------------------------------------
// crc_bit_serial_encode_check - bit-serial crc encoder and checker
// Programmable generator and degree; one message bit per word.
// ----------------------------------------------------------------------------
// Input words (command, data_bit, last_bit) go in through push/full; result
// words come out through empty/pop, oldest first. The generator is written
// on the cfg channel (index 0 low coefficients, index 1 degree) while idle,
// a rule on the user that the block does not enforce; cfg_ready is always high.
// A word enters a four-deep queue, the divider takes one word a cycle from
// it while it is not busy with a crc tail and, but for a non-last check word,
// the output queue has room; its result sits in a two-word output queue
// and is registered there before it reaches the result ports. Encode and
// check bits run at one bit per cycle under the same conditions. After an
// encode word marked last, the remainder register first shifts in d zeros
// and then shifts the d crc bits out, one per cycle while the output queue
// has room. A check word marked last gives one verdict word with the remainder.
// Reset empties both queues, clears the remainder and sets the generator
// to zero with degree one. When the receiver stops popping, the output
// queue fills, the divider halts at the next word that needs a result slot
// and the input queue raises full after four more words.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_bit_serial_encode_check #(
  parameter int MAX_DEGREE = cbec_pkg::MAX_DEGREE_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              command,
  input  wire logic                              data_bit,
  input  wire logic                              last_bit,
  input  wire logic                              pop,
  output logic                                   empty,
  output logic                                   code_bit,
  output logic                                   is_check_bit,
  output logic                                   end_of_run,
  output logic                                   is_verdict,
  output logic [cbec_pkg::REM_OUT_W-1:0]         remainder_value,
  output logic                                   error_found,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cbec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbec_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [cbec_pkg::GEN_LOW_W-1:0]  gen_low;
  logic [cbec_pkg::DEG_CFG_W-1:0]  gen_degree;
  cbec_pkg::head_t                 head;
  logic                            take;
  cbec_pkg::result_t               result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_low    <= cbec_pkg::GEN_LOW_RESET;
      gen_degree <= cbec_pkg::GEN_DEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbec_pkg::REG_GEN_LOW: gen_low    <= cfg_data[cbec_pkg::GEN_LOW_W-1:0];
        cbec_pkg::REG_GEN_DEG: gen_degree <= cfg_data[cbec_pkg::DEG_CFG_W-1:0];
        default:               gen_low    <= gen_low;
      endcase
    end
  end

  cbec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .command  (command),
    .data_bit (data_bit),
    .last_bit (last_bit),
    .head     (head),
    .take     (take)
  );

  cbec_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .gen_low    (gen_low),
    .gen_degree (gen_degree),
    .head       (head),
    .take       (take),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  assign code_bit        = result.code_bit;
  assign is_check_bit    = result.is_check_bit;
  assign end_of_run      = result.end_of_run;
  assign is_verdict      = result.is_verdict;
  assign remainder_value = result.remainder_value;
  assign error_found     = result.error_found;

`ifndef NO_ASSERTIONS
  // both queues come out of reset empty
  a_reset_empty : assert property (@(posedge clk) rst |=> (!full && empty))
    else $error("queues not empty after reset");

  // a verdict word never carries a crc bit
  a_verdict_clean : assert property (@(posedge clk) disable iff (rst)
    (!empty && is_verdict) |-> (!is_check_bit && !code_bit && end_of_run))
    else $error("verdict word carries code bits");

  // a nonzero remainder is always flagged
  a_error_flag : assert property (@(posedge clk) disable iff (rst)
    (!empty && is_verdict && (remainder_value != '0)) |-> error_found)
    else $error("nonzero remainder without error flag");
`endif

endmodule

`default_nettype wire

// ===== verif/crc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// crc_tb_pkg - command codes and limits shared by the crc testbench
// Values of the one-bit command port and the longest idle gap per word.
// ----------------------------------------------------------------------------
package crc_tb_pkg;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  localparam int IDLE_MAX = 19;

endpackage

// ===== verif/crc_stream_checker.sv =====
// ----------------------------------------------------------------------------
// crc_stream_checker - predicts and checks the result words of the crc block
// Follows the generator writes and every accepted input word, runs its own
// bit-serial division and compares each popped word, field by field, with
// the oldest predicted one. Hands back the failure count and the number of
// words still owed.
// ----------------------------------------------------------------------------
module crc_stream_checker
  import cbec_pkg::*;
  import crc_tb_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic                  command,
  input  logic                  data_bit,
  input  logic                  last_bit,
  input  logic                  pop,
  input  logic                  empty,
  input  logic                  code_bit,
  input  logic                  is_check_bit,
  input  logic                  end_of_run,
  input  logic                  is_verdict,
  input  logic [REM_OUT_W-1:0]  remainder_value,
  input  logic                  error_found,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    results_owed,
  output int                    mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [GEN_LOW_W-1:0] gen_low;
  logic [DEG_CFG_W-1:0] gen_deg;
  logic [63:0]          crc_rem;
  result_t              pending_results[$];

  // out-of-range degrees are clamped, never rejected
  function automatic int unsigned degree_in_use(logic [DEG_CFG_W-1:0] deg);
    if (deg == 0) begin
      return 1;
    end
    if (deg > MAX_DEGREE) begin
      return MAX_DEGREE;
    end
    return deg;
  endfunction

  function automatic logic [63:0] shift_crc(logic [63:0] r, logic b, int unsigned d,
                                            logic [63:0] poly);
    logic [63:0] mask;
    logic [63:0] nxt;
    mask = (64'd1 << d) - 64'd1;
    nxt  = ((r << 1) | {63'd0, b}) & mask;
    if (r[d-1]) begin
      nxt = nxt ^ (poly & mask);
    end
    return nxt;
  endfunction

  task automatic divide_word(logic cmd, logic b, logic last);
    int unsigned d;
    logic [63:0] mask;
    logic [63:0] poly;
    result_t     r;
    d       = degree_in_use(gen_deg);
    mask    = (64'd1 << d) - 64'd1;
    poly    = {32'd0, gen_low};
    crc_rem = shift_crc(crc_rem & mask, b, d, poly);
    if (cmd == CMD_ENCODE) begin
      r          = '0;
      r.code_bit = b;
      pending_results.push_back(r);
      if (last) begin
        // append d zeros, then the remainder leaves msb first
        repeat (d) crc_rem = shift_crc(crc_rem, 1'b0, d, poly);
        for (int k = d - 1; k >= 0; k--) begin
          r              = '0;
          r.code_bit     = crc_rem[k];
          r.is_check_bit = 1'b1;
          r.end_of_run   = (k == 0);
          pending_results.push_back(r);
        end
        crc_rem = '0;
      end
    end else if (last) begin
      r                 = '0;
      r.end_of_run      = 1'b1;
      r.is_verdict      = 1'b1;
      r.remainder_value = crc_rem[REM_OUT_W-1:0];
      r.error_found     = (crc_rem != 0);
      pending_results.push_back(r);
      crc_rem = '0;
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("t=%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      gen_low = GEN_LOW_RESET;
      gen_deg = GEN_DEG_RESET;
      crc_rem = '0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GEN_LOW: gen_low = cfg_data[GEN_LOW_W-1:0];
          REG_GEN_DEG: gen_deg = cfg_data[DEG_CFG_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        divide_word(command, data_bit, last_bit);
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("t=%0t: result word with none expected, got code_bit %0b verdict %0b",
                   $time, code_bit, is_verdict);
        end else begin
          want = pending_results.pop_front();
          compare_field("code_bit", want.code_bit, code_bit);
          compare_field("is_check_bit", want.is_check_bit, is_check_bit);
          compare_field("end_of_run", want.end_of_run, end_of_run);
          compare_field("is_verdict", want.is_verdict, is_verdict);
          compare_field("remainder_value", want.remainder_value, remainder_value);
          compare_field("error_found", want.error_found, error_found);
        end
      end
    end
    results_owed <= pending_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - top level for the bit-serial crc encoder and checker
// Drives directed and random messages through the queue-style ports, with
// random gaps on both sides, under a series of generator settings. Encoded
// messages are often fed back as codewords, clean or with one bit flipped.
// The checker beside the block does the prediction; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;
  import cbec_pkg::*;
  import crc_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 80;
  localparam int WORD_TARGET   = 435;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  command   = 1'b0;
  logic                  data_bit  = 1'b0;
  logic                  last_bit  = 1'b0;
  logic                  pop       = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  full;
  logic                  empty;
  logic                  code_bit;
  logic                  is_check_bit;
  logic                  end_of_run;
  logic                  is_verdict;
  logic [REM_OUT_W-1:0]  remainder_value;
  logic                  error_found;
  logic                  cfg_ready;
  int                    results_owed;
  int                    mismatch_count;

  bit   tx_idle = 1'b0;
  bit   rx_idle = 1'b1;
  int   words_sent = 0;
  int   quiet_cycles = 0;
  logic crc_tail[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crc_bit_serial_encode_check i_dut (.*);

  crc_stream_checker i_checker (.*);

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random pops, crc bits kept for the codeword feedback
  initial begin
    int gap;
    forever begin
      gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (rst || empty);
      if (is_check_bit) begin
        crc_tail.push_back(code_bit);
      end
    end
  end

  task automatic send_word(logic c, logic b, logic l);
    int gap;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    command  <= c;
    data_bit <= b;
    last_bit <= l;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // non-last check words give no result, so allow the pipe to empty too
  task automatic idle_for_config();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_generator(logic [GEN_LOW_W-1:0] low, logic [DEG_CFG_W-1:0] deg);
    bit                    deg_first;
    logic [CFG_DATA_W-1:0] deg_word;
    deg_first                = 1'($urandom_range(0, 1));
    deg_word                 = $urandom;
    deg_word[DEG_CFG_W-1:0]  = deg;
    cfg_valid <= 1'b1;
    cfg_index <= deg_first ? REG_GEN_DEG : REG_GEN_LOW;
    cfg_data  <= deg_first ? deg_word : low;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= deg_first ? REG_GEN_LOW : REG_GEN_DEG;
    cfg_data  <= deg_first ? low : deg_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // bits[len-1] goes first
  task automatic send_run(logic c, logic [63:0] bits, int len);
    for (int i = len - 1; i >= 0; i--) begin
      send_word(c, bits[i], i == 0);
    end
  endtask

  task automatic send_message(logic c, bit mixed, int len);
    for (int i = 0; i < len; i++) begin
      send_word(mixed ? 1'($urandom_range(0, 1)) : c, 1'($urandom_range(0, 1)),
                i == len - 1);
    end
  endtask

  task automatic encode_then_check(int len, bit corrupt);
    logic msg[$];
    logic codeword[$];
    int   flip;
    wait_drained();
    crc_tail.delete();
    for (int i = 0; i < len; i++) begin
      msg.push_back(1'($urandom_range(0, 1)));
    end
    foreach (msg[i]) begin
      send_word(CMD_ENCODE, msg[i], i == len - 1);
    end
    wait_drained();
    codeword = {msg, crc_tail};
    if (corrupt) begin
      flip           = $urandom_range(0, codeword.size() - 1);
      codeword[flip] = ~codeword[flip];
    end
    foreach (codeword[i]) begin
      send_word(CMD_CHECK, codeword[i], i == codeword.size() - 1);
    end
  endtask

  initial begin
    int                   len;
    int                   pick;
    logic [GEN_LOW_W-1:0] low;
    logic [DEG_CFG_W-1:0] deg;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // generator after reset: x, degree one
    send_run(CMD_ENCODE, 64'b10, 2);
    send_run(CMD_CHECK, 64'b1, 1);

    idle_for_config();
    write_generator(32'h0000_0007, 6'd8);
    send_run(CMD_ENCODE, 64'b10, 2);
    // clean codeword of the one-bit message, remainder zero
    send_run(CMD_CHECK, 64'b1_0000_0111, 9);
    // modes mixed within one message
    send_word(CMD_ENCODE, 1'b1, 1'b0);
    send_word(CMD_CHECK, 1'b1, 1'b0);
    send_word(CMD_ENCODE, 1'b0, 1'b1);

    // degree zero acts as one, coefficients above it ignored
    idle_for_config();
    write_generator(32'hFFFF_FFFF, 6'd0);
    send_run(CMD_ENCODE, 64'b1, 1);
    send_run(CMD_CHECK, 64'b1, 1);

    // degree above the maximum clamps to it
    idle_for_config();
    write_generator(32'h04C1_1DB7, 6'd63);
    send_run(CMD_ENCODE, 64'b1, 1);
    send_run(CMD_CHECK, 64'b0, 1);

    idle_for_config();
    write_generator(32'hFFFF_FFFF, 6'd32);
    send_run(CMD_ENCODE, 64'b11, 2);
    send_run(CMD_CHECK, 64'b01, 2);

    idle_for_config();
    write_generator(32'h0000_0000, 6'd33);
    send_run(CMD_CHECK, 64'b1, 1);

    while (words_sent < WORD_TARGET) begin
      idle_for_config();
      case ($urandom_range(0, 3))
        0:       low = '0;
        1:       low = '1;
        default: low = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       deg = DEG_CFG_W'($urandom_range(0, 1));
        1:       deg = DEG_CFG_W'($urandom_range(32, 63));
        2:       deg = DEG_CFG_W'($urandom_range(17, 31));
        default: deg = DEG_CFG_W'($urandom_range(2, 16));
      endcase
      write_generator(low, deg);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) begin
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          encode_then_check(len, $urandom_range(0, 2) == 0);
        end else if (pick < 6) begin
          send_message(CMD_ENCODE, 1'b0, len);
        end else if (pick < 8) begin
          send_message(CMD_CHECK, 1'b0, len);
        end else if (pick == 8) begin
          send_message(CMD_ENCODE, 1'b1, len);
        end else begin
          // stray words, may leave a partial message in the register
          repeat ($urandom_range(1, 3)) begin
            send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
